// ----- src/flvp_pkg.sv -----
// ----------------------------------------------------------------------------
// flvp_pkg
// Shared widths and request types for the focal length from vanishing
// points block.
// ----------------------------------------------------------------------------
package flvp_pkg;

  // Coordinate and result formats.
  localparam int unsigned CoordWidth = 32;
  localparam int unsigned OutWidth   = 32;

  // Derived datapath widths.
  localparam int unsigned DiffW  = CoordWidth + 1;     // coordinate differences
  localparam int unsigned ProdW  = 2 * DiffW;          // products, also |d|^2
  localparam int unsigned DotW   = ProdW + 1;          // dot and cross products
  localparam int unsigned MagW   = ProdW + 1;          // magnitudes for the wide multiply
  localparam int unsigned LoW    = (MagW + 1) / 2;     // low half of a split operand
  localparam int unsigned HiW    = MagW - LoW;         // high half of a split operand
  localparam int unsigned MidW   = LoW + HiW + 1;      // sum of the two cross terms
  localparam int unsigned NumW   = 2 * MagW;           // numerator magnitude
  localparam int unsigned QuoW   = 2 * OutWidth;       // saturated quotient
  localparam int unsigned NumHiW = NumW - QuoW;        // numerator above the quotient bits
  localparam int unsigned RemW   = ProdW + 1;          // division trial value
  localparam int unsigned RmW    = OutWidth + 3;       // square root remainder

  typedef struct packed {
    logic signed [CoordWidth-1:0] first_vp_x;
    logic signed [CoordWidth-1:0] first_vp_y;
    logic signed [CoordWidth-1:0] second_vp_x;
    logic signed [CoordWidth-1:0] second_vp_y;
    logic signed [CoordWidth-1:0] center_x;
    logic signed [CoordWidth-1:0] center_y;
  } flvp_in_t;

  typedef struct packed {
    logic [OutWidth-1:0] focal_length;
    logic                valid_res;
  } flvp_out_t;

endpackage

// ----- src/flvp_pipe.sv -----
// ----------------------------------------------------------------------------
// flvp_pipe
// Stalling datapath pipeline: products, wide numerator, restoring division
// by |d|^2 and a restoring square root, one step per stage.
// ----------------------------------------------------------------------------
module flvp_pipe (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 in_valid_i,
  input  flvp_pkg::flvp_in_t   in_data_i,
  output logic                 out_valid_o,
  output flvp_pkg::flvp_out_t  out_data_o
);
  import flvp_pkg::*;

  // Stage 1: differences.
  logic signed [DiffW-1:0] ax, ay, bx, by, px, py;
  logic signed [DiffW-1:0] dx_q, dy_q, ex_q, ey_q;
  logic                    v1_q;

  assign ax = {in_data_i.first_vp_x[CoordWidth-1], in_data_i.first_vp_x};
  assign ay = {in_data_i.first_vp_y[CoordWidth-1], in_data_i.first_vp_y};
  assign bx = {in_data_i.second_vp_x[CoordWidth-1], in_data_i.second_vp_x};
  assign by = {in_data_i.second_vp_y[CoordWidth-1], in_data_i.second_vp_y};
  assign px = {in_data_i.center_x[CoordWidth-1], in_data_i.center_x};
  assign py = {in_data_i.center_y[CoordWidth-1], in_data_i.center_y};

  // Stage 2: six products.
  logic signed [ProdW-1:0] p_xx_q, p_yy_q, p_xe_q, p_ye_q, p_xey_q, p_yex_q;
  logic                    v2_q;

  // Stage 3: D, s and c.
  logic [ProdW-1:0]       dd3_q;
  logic signed [DotW-1:0] s_q, c_q;
  logic signed [DotW-1:0] s_d, c_d;
  logic                   v3_q;

  assign s_d = {p_xe_q[ProdW-1], p_xe_q} + {p_ye_q[ProdW-1], p_ye_q};
  assign c_d = {p_xey_q[ProdW-1], p_xey_q} - {p_yex_q[ProdW-1], p_yex_q};

  // Stage 4: magnitudes of s, D - s and c.
  logic [DotW:0]    t_d, t_neg;
  logic [DotW-1:0]  s_neg, c_neg;
  logic [MagW-1:0]  ma_q, mb_q, mc_q;
  logic [ProdW-1:0] dd4_q;
  logic             dz4_q, v4_q;

  assign t_d   = {2'b00, dd3_q} - {s_q[DotW-1], s_q};
  assign t_neg = -t_d;
  assign s_neg = -s_q;
  assign c_neg = -c_q;

  // Stage 5: partial products.
  logic [2*LoW-1:0]   pll_q, cll_q;
  logic [LoW+HiW-1:0] plh_q, phl_q, clh_q;
  logic [2*HiW-1:0]   phh_q, chh_q;
  logic [ProdW-1:0]   dd5_q;
  logic               dz5_q, v5_q;

  // Stage 6: cross term sums.
  logic [2*LoW-1:0] pll6_q, cll6_q;
  logic [MidW-1:0]  pm_q, cm_q;
  logic [2*HiW-1:0] phh6_q, chh6_q;
  logic [ProdW-1:0] dd6_q;
  logic             dz6_q, v6_q;

  // Stage 7: full products.
  logic [NumW-1:0]  pp_q, qq_q;
  logic [ProdW-1:0] dd7_q;
  logic             dz7_q, v7_q;

  // Stage 8: numerator and its sign.
  logic [NumW:0]    num_d;
  logic [NumW-1:0]  num_q;
  logic [ProdW-1:0] dd8_q;
  logic             ok8_q, v8_q;

  assign num_d = {1'b0, pp_q} - {1'b0, qq_q};

  // Division stages: index 0 is the saturation check, then one quotient bit
  // per stage.
  logic [ProdW-1:0] dr_q [QuoW+1];
  logic [QuoW-1:0]  dw_q [QuoW+1];
  logic [ProdW-1:0] ddp_q [QuoW+1];
  logic             dok_q [QuoW+1];
  logic             dsat_q [QuoW+1];
  logic             dv_q [QuoW+1];
  logic [ProdW-1:0] dr_d [QuoW];
  logic [QuoW-1:0]  dw_d [QuoW];
  logic             dsat0_d;

  assign dsat0_d = num_q[NumW-1:QuoW] >= NumHiW'(dd8_q);

  always_comb begin
    for (int i = 0; i < QuoW; i++) begin
      logic [RemW-1:0] trial;
      logic            ge;
      trial    = {dr_q[i], dw_q[i][QuoW-1]};
      ge       = trial >= {1'b0, ddp_q[i]};
      dr_d[i]  = ge ? ProdW'(trial - {1'b0, ddp_q[i]}) : trial[ProdW-1:0];
      dw_d[i]  = {dw_q[i][QuoW-2:0], ge};
    end
  end

  // Square root stages. The input of the first one is taken straight from
  // the division output, the others from the stage registers.
  logic [RmW-1:0]      sr_q [1:OutWidth];
  logic [OutWidth-1:0] sq_q [1:OutWidth];
  logic [QuoW-1:0]     sx_q [1:OutWidth];
  logic                sok_q [1:OutWidth];
  logic                sv_q [1:OutWidth];
  logic [RmW-1:0]      sr_c [OutWidth];
  logic [OutWidth-1:0] sq_c [OutWidth];
  logic [QuoW-1:0]     sx_c [OutWidth];
  logic [RmW-1:0]      sr_d [OutWidth];
  logic [OutWidth-1:0] sq_d [OutWidth];
  logic [QuoW-1:0]     sx_d [OutWidth];

  always_comb begin
    sr_c[0] = '0;
    sq_c[0] = '0;
    sx_c[0] = dsat_q[QuoW] ? '1 : dw_q[QuoW];
    for (int j = 1; j < OutWidth; j++) begin
      sr_c[j] = sr_q[j];
      sq_c[j] = sq_q[j];
      sx_c[j] = sx_q[j];
    end
  end

  always_comb begin
    for (int j = 0; j < OutWidth; j++) begin
      logic [RmW-1:0] trial;
      logic [RmW-1:0] tgt;
      logic           ge;
      trial   = {sr_c[j][RmW-3:0], sx_c[j][QuoW-1:QuoW-2]};
      tgt     = {1'b0, sq_c[j], 2'b01};
      ge      = trial >= tgt;
      sr_d[j] = ge ? trial - tgt : trial;
      sq_d[j] = {sq_c[j][OutWidth-2:0], ge};
      sx_d[j] = {sx_c[j][QuoW-3:0], 2'b00};
    end
  end

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
      v8_q <= 1'b0;
      for (int i = 0; i <= QuoW; i++) dv_q[i] <= 1'b0;
      for (int j = 1; j <= OutWidth; j++) sv_q[j] <= 1'b0;
    end else if (en_i) begin
      v1_q    <= in_valid_i;
      v2_q    <= v1_q;
      v3_q    <= v2_q;
      v4_q    <= v3_q;
      v5_q    <= v4_q;
      v6_q    <= v5_q;
      v7_q    <= v6_q;
      v8_q    <= v7_q;
      dv_q[0] <= v8_q;
      for (int i = 1; i <= QuoW; i++) dv_q[i] <= dv_q[i-1];
      sv_q[1] <= dv_q[QuoW];
      for (int j = 2; j <= OutWidth; j++) sv_q[j] <= sv_q[j-1];
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dx_q <= ax - bx;
      dy_q <= ay - by;
      ex_q <= px - bx;
      ey_q <= py - by;

      p_xx_q  <= dx_q * dx_q;
      p_yy_q  <= dy_q * dy_q;
      p_xe_q  <= dx_q * ex_q;
      p_ye_q  <= dy_q * ey_q;
      p_xey_q <= dx_q * ey_q;
      p_yex_q <= dy_q * ex_q;

      dd3_q <= $unsigned(p_xx_q) + $unsigned(p_yy_q);
      s_q   <= s_d;
      c_q   <= c_d;

      ma_q  <= s_q[DotW-1] ? MagW'(s_neg) : MagW'(s_q);
      mb_q  <= t_d[DotW] ? MagW'(t_neg) : MagW'(t_d);
      mc_q  <= c_q[DotW-1] ? MagW'(c_neg) : MagW'(c_q);
      dd4_q <= dd3_q;
      dz4_q <= (dd3_q == '0);

      pll_q <= ma_q[LoW-1:0] * mb_q[LoW-1:0];
      plh_q <= ma_q[LoW-1:0] * mb_q[MagW-1:LoW];
      phl_q <= ma_q[MagW-1:LoW] * mb_q[LoW-1:0];
      phh_q <= ma_q[MagW-1:LoW] * mb_q[MagW-1:LoW];
      cll_q <= mc_q[LoW-1:0] * mc_q[LoW-1:0];
      clh_q <= mc_q[LoW-1:0] * mc_q[MagW-1:LoW];
      chh_q <= mc_q[MagW-1:LoW] * mc_q[MagW-1:LoW];
      dd5_q <= dd4_q;
      dz5_q <= dz4_q;

      pll6_q <= pll_q;
      cll6_q <= cll_q;
      phh6_q <= phh_q;
      chh6_q <= chh_q;
      pm_q   <= MidW'(plh_q) + MidW'(phl_q);
      cm_q   <= {clh_q, 1'b0};
      dd6_q  <= dd5_q;
      dz6_q  <= dz5_q;

      pp_q  <= (NumW'(phh6_q) << (2 * LoW)) + (NumW'(pm_q) << LoW) + NumW'(pll6_q);
      qq_q  <= (NumW'(chh6_q) << (2 * LoW)) + (NumW'(cm_q) << LoW) + NumW'(cll6_q);
      dd7_q <= dd6_q;
      dz7_q <= dz6_q;

      num_q <= num_d[NumW-1:0];
      dd8_q <= dd7_q;
      ok8_q <= !dz7_q && !num_d[NumW] && (num_d[NumW-1:0] != '0);

      dr_q[0]   <= num_q[QuoW+ProdW-1:QuoW];
      dw_q[0]   <= num_q[QuoW-1:0];
      ddp_q[0]  <= dd8_q;
      dok_q[0]  <= ok8_q;
      dsat_q[0] <= dsat0_d;
      for (int i = 1; i <= QuoW; i++) begin
        dr_q[i]   <= dr_d[i-1];
        dw_q[i]   <= dw_d[i-1];
        ddp_q[i]  <= ddp_q[i-1];
        dok_q[i]  <= dok_q[i-1];
        dsat_q[i] <= dsat_q[i-1];
      end

      sok_q[1] <= dok_q[QuoW];
      for (int j = 1; j <= OutWidth; j++) begin
        sr_q[j] <= sr_d[j-1];
        sq_q[j] <= sq_d[j-1];
        sx_q[j] <= sx_d[j-1];
      end
      for (int j = 2; j <= OutWidth; j++) sok_q[j] <= sok_q[j-1];
    end
  end

  assign out_valid_o             = sv_q[OutWidth];
  assign out_data_o.focal_length = sok_q[OutWidth] ? sq_q[OutWidth] : '0;
  assign out_data_o.valid_res    = sok_q[OutWidth];

endmodule

// ----- src/focal_length_from_vanishing_points.sv -----
// ----------------------------------------------------------------------------
// focal_length_from_vanishing_points
// Relative focal length from two vanishing points and a principal point.
// ----------------------------------------------------------------------------
// The block takes one request per clock cycle while the output queue has
// room and returns one result per request, in order. The datapath has
// eight stages of products and wide sums, one saturation check, 64
// restoring division stages (one quotient bit each) and 32 square root
// stages (one root bit each). A two-entry output queue sits between the
// pipeline and the result port, so new requests keep entering while a
// finished result waits; when the queue is full the whole pipeline holds.
// The result is the floor of the square root of the squared focal length
// in Q16.16, saturated to all ones; it is zero with valid_res low when the
// vanishing points coincide or the squared focal length is not positive.
module focal_length_from_vanishing_points (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  flvp_pkg::flvp_in_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output flvp_pkg::flvp_out_t  out_data_o
);
  import flvp_pkg::*;

  localparam logic [1:0] FifoFull = 2'd2;

  logic      pipe_en;
  logic      pipe_valid;
  flvp_out_t pipe_data;

  // Two-entry output queue.
  flvp_out_t  mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  // The pipeline advances whenever the output queue has room. Since that
  // decision comes from registered state, every item that leaves the last
  // stage always finds a free entry.
  assign pipe_en    = (cnt_q != FifoFull);
  assign in_ready_o = pipe_en;

  flvp_pipe u_pipe (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (pipe_en),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .out_valid_o(pipe_valid),
    .out_data_o (pipe_data)
  );

  assign push = pipe_en && pipe_valid;
  assign pop  = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) wptr_q <= !wptr_q;
      if (pop) rptr_q <= !rptr_q;
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wptr_q] <= pipe_data;
  end

  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = mem_q[rptr_q];

  // The queue never holds more than two results.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FifoFull)
    else $error("output queue overflow");

  // A result leaving the pipeline with no pop grows the queue by one.
  a_cnt_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (cnt_q == $past(cnt_q) + 2'd1))
    else $error("output queue count did not grow on push");

  // A request is never taken while the queue is full.
  a_no_accept_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == FifoFull) |-> !in_ready_o)
    else $error("request accepted with a full output queue");

  // An invalid result always carries a zero focal length.
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.valid_res) |-> (out_data_o.focal_length == '0))
    else $error("invalid result with nonzero focal length");

endmodule

// ----- dv/focal_length_from_vanishing_points_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// focal_length_from_vanishing_points_tb
// Self-checking bench for the focal length block. Requests are pulled from
// a pending queue by a clocked driver. For every accepted request an exact
// wide-integer predictor works out the focal length and the valid flag. A
// clocked monitor compares each accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
module focal_length_from_vanishing_points_tb;
  import flvp_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned DrainWait  = 150;
  localparam int unsigned NumRandom  = 1230;
  // Cycles in which neither side idles, so that full-rate flow is seen too.
  localparam int unsigned CalmFirst  = 600;
  localparam int unsigned CalmLast   = 1100;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  flvp_in_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  flvp_out_t out_data_o;

  flvp_in_t    pending_reqs[$];
  flvp_out_t   predicted_focals[$];
  int unsigned cycle_count = 0;
  int unsigned fail_count = 0;

  always #6 clk_i = ~clk_i;

  focal_length_from_vanishing_points dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // Exact prediction. With d = Fu - Fv and e = P - Fv, the squared focal
  // length is (|s*(D-s)| - c*c) / D where D = d.d, s = d.e and c = d x e.
  // The root is the largest 32-bit value r with r*r*D <= numerator, so it
  // saturates to all ones by construction.
  function automatic flvp_out_t predict_focal(flvp_in_t r);
    logic signed [255:0] ax, ay, bx, by, px, py;
    logic signed [255:0] dx, dy, ex, ey, dd, s, c, num, cw;
    logic [31:0]         root, cand;
    flvp_out_t           res;
    ax = r.first_vp_x;
    ay = r.first_vp_y;
    bx = r.second_vp_x;
    by = r.second_vp_y;
    px = r.center_x;
    py = r.center_y;
    dx = ax - bx;
    dy = ay - by;
    ex = px - bx;
    ey = py - by;
    dd = dx * dx + dy * dy;
    s  = dx * ex + dy * ey;
    c  = dx * ey - dy * ex;
    res = '0;
    if (dd == 0) begin
      return res;
    end
    num = s * (dd - s);
    if (num < 0) begin
      num = -num;
    end
    num = num - c * c;
    if (num <= 0) begin
      return res;
    end
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      cand = root | (32'd1 << b);
      cw = {224'd0, cand};
      if (cw * cw * dd <= num) begin
        root = cand;
      end
    end
    res.focal_length = root;
    res.valid_res = 1'b1;
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    fail_count++;
    $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  task automatic queue_points(input logic [31:0] ax, input logic [31:0] ay,
                              input logic [31:0] bx, input logic [31:0] by,
                              input logic [31:0] px, input logic [31:0] py);
    flvp_in_t r;
    r.first_vp_x  = ax;
    r.first_vp_y  = ay;
    r.second_vp_x = bx;
    r.second_vp_y = by;
    r.center_x    = px;
    r.center_y    = py;
    pending_reqs.push_back(r);
  endtask

  // Uniform value in [-2^sc, 2^sc - 1], sc at most 30.
  function automatic logic [31:0] spread(input int unsigned sc);
    longint v;
    v = longint'($urandom_range(0, (32'd1 << (sc + 1)) - 1)) - (longint'(1) << sc);
    return v[31:0];
  endfunction

  // An idle decision for one side; a calm window keeps both sides busy.
  function automatic logic take_break();
    if (cycle_count >= CalmFirst && cycle_count < CalmLast) begin
      return 1'b0;
    end
    return $urandom_range(0, 99) < 31;
  endfunction

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Driver: a request leaves the pending queue only when the previous one has
  // been taken, so valid and payload hold steady until acceptance. The
  // prediction is made on acceptance, which keeps the expected order exact.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        predicted_focals.push_back(predict_focal(in_data_i));
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_reqs.size() != 0 && !take_break()) begin
          in_data_i  <= pending_reqs.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks every accepted result against the oldest prediction and
  // stalls the output side at random.
  always @(posedge clk_i or negedge rst_ni) begin
    flvp_out_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (predicted_focals.size() == 0) begin
          report_mismatch("result with no request outstanding");
        end else begin
          want = predicted_focals.pop_front();
          if (out_data_o.focal_length !== want.focal_length) begin
            report_mismatch($sformatf("focal_length got %h want %h",
                                      out_data_o.focal_length, want.focal_length));
          end
          if (out_data_o.valid_res !== want.valid_res) begin
            report_mismatch($sformatf("valid_res got %b want %b",
                                      out_data_o.valid_res, want.valid_res));
          end
        end
      end
      out_ready_i <= !take_break();
    end
  end

  initial begin
    logic [31:0] ax, ay, bx, by;
    int unsigned kind, sc;

    // Directed requests. Coinciding vanishing points, at zero and elsewhere.
    queue_points('0, '0, '0, '0, '0, '0);
    queue_points(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                 32'h1234_5678, 32'hfedc_ba98);
    // Extreme corners, with the principal point at the middle and at a corner.
    queue_points(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, '0, '0);
    queue_points(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, '0, '0);
    queue_points(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
                 32'hffff_ffff, 32'h0000_0001);
    queue_points(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                 32'h8000_0000, 32'h7fff_ffff);
    queue_points(32'hffff_ffff, 32'hffff_ffff, '0, '0, 32'h7fff_ffff, 32'h7fff_ffff);
    // One raw unit on either side of the principal point.
    queue_points(32'd1, '0, 32'hffff_ffff, '0, '0, '0);
    // Principal point on one vanishing point: squared length exactly zero.
    queue_points(32'd2, '0, '0, '0, '0, '0);
    // Foot point outside the segment, so the product term changes sign.
    queue_points(32'd2, '0, '0, '0, 32'd5, '0);
    // Principal point far off the line: negative squared length.
    queue_points(32'h0001_0000, '0, 32'hffff_0000, '0, '0, 32'h0010_0000);
    // Small squared lengths of two, one and eight raw units squared.
    queue_points(32'd3, 32'd1, '0, '0, 32'd1, '0);
    queue_points(32'd2, 32'd1, '0, '0, 32'd1, '0);
    queue_points(32'd7, 32'd3, '0, '0, 32'd1, 32'd1);
    // A typical camera: vanishing points wide apart, center near the origin.
    queue_points(32'hfff0_0000, 32'h0000_8000, 32'h0012_0000, 32'h0001_0000,
                 32'h0000_1000, 32'hffff_f000);
    queue_points(32'hffff_ffff, 32'hffff_ffff, 32'h8000_0000, 32'h8000_0000,
                 32'h8000_0000, 32'hffff_ffff);

    // Random part: mostly well-placed centers so that valid results are
    // common, plus tiny coordinates and fully random noise.
    for (int n = 0; n < NumRandom; n++) begin
      kind = $urandom_range(0, 9);
      if (kind < 2) begin
        queue_points($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      end else if (kind < 4) begin
        queue_points(spread(2), spread(2), spread(2), spread(2), spread(2), spread(2));
      end else begin
        sc = $urandom_range(2, 30);
        ax = spread(sc);
        ay = spread(sc);
        bx = spread(sc);
        by = spread(sc);
        queue_points(ax, ay, bx, by,
                     ((ax >>> 1) | (ax & 32'h8000_0000)) + ((bx >>> 1) | (bx & 32'h8000_0000))
                       + spread(sc - 2),
                     ((ay >>> 1) | (ay & 32'h8000_0000)) + ((by >>> 1) | (by & 32'h8000_0000))
                       + spread(sc - 2));
      end
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (pending_reqs.size() == 0 && !in_valid_i && predicted_focals.size() == 0);
    repeat (DrainWait) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
